FILE: design/afc_pkg.sv
// afc_pkg: shared constants, types and field helpers for the bounding-box
// frustum culler. No dependencies; imported by every afc_* module.
package afc_pkg;

   localparam int NUM_PLANES      = 6;
   localparam int FIELD_WIDTH     = 16;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int WORD_WIDTH      = 64;
   localparam int PROD_WIDTH      = 2 * FIELD_WIDTH;
   localparam int ACC_WIDTH       = PROD_WIDTH + 2;
   localparam int FRAC_SHIFT      = 12;
   localparam int RND_WIDTH       = ACC_WIDTH - FRAC_SHIFT;
   localparam int ROUND_BIAS      = 2048;
   localparam int D_SHIFT         = 14;
   localparam int CSR_ADDR_WIDTH  = 6;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_IDX_LSB     = 3;
   localparam int REQ_DATA_WIDTH  = 288;
   localparam int RSP_DATA_WIDTH  = 8;

   typedef logic [WORD_WIDTH-1:0]         word_type;
   typedef logic signed [FIELD_WIDTH-1:0] field_type;

   // Register indexes of the plane file
   typedef enum logic [2:0] {
      REG_PLANE_LEFT   = 3'd0,
      REG_PLANE_RIGHT  = 3'd1,
      REG_PLANE_BOTTOM = 3'd2,
      REG_PLANE_TOP    = 3'd3,
      REG_PLANE_FAR    = 3'd4,
      REG_PLANE_NEAR   = 3'd5
   } reg_idx_type;

   // Lanes of a packed 64-bit word: 0..2 are x,y,z coefficients or normal,
   // lane 3 is translation or plane offset.
   localparam logic [1:0] LANE_X = 2'd0;
   localparam logic [1:0] LANE_Y = 2'd1;
   localparam logic [1:0] LANE_Z = 2'd2;
   localparam logic [1:0] LANE_W = 2'd3;

   function automatic field_type lane16(input word_type w, input logic [1:0] idx);
      return field_type'(w[{idx, 4'b0000} +: FIELD_WIDTH]);
   endfunction

endpackage

FILE: design/afc_csr.sv
// afc_csr: APB-style register file holding the six 64-bit frustum planes.
// Depends on afc_pkg.
module afc_csr
   import afc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output word_type                  planes [NUM_PLANES]
);

   word_type    plane_ff [NUM_PLANES];
   logic        wr_en;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_WIDTH-1:CSR_IDX_LSB]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) plane_ff[i] <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_PLANE_LEFT:   plane_ff[0] <= csr_pwdata;
            REG_PLANE_RIGHT:  plane_ff[1] <= csr_pwdata;
            REG_PLANE_BOTTOM: plane_ff[2] <= csr_pwdata;
            REG_PLANE_TOP:    plane_ff[3] <= csr_pwdata;
            REG_PLANE_FAR:    plane_ff[4] <= csr_pwdata;
            REG_PLANE_NEAR:   plane_ff[5] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_PLANE_LEFT:   csr_prdata = plane_ff[0];
         REG_PLANE_RIGHT:  csr_prdata = plane_ff[1];
         REG_PLANE_BOTTOM: csr_prdata = plane_ff[2];
         REG_PLANE_TOP:    csr_prdata = plane_ff[3];
         REG_PLANE_FAR:    csr_prdata = plane_ff[4];
         REG_PLANE_NEAR:   csr_prdata = plane_ff[5];
         default:          csr_prdata = '0;
      endcase
   end

   assign planes = plane_ff;

endmodule

FILE: design/afc_xform.sv
// afc_xform: three-stage pipeline that transforms both box corners to world
// space, rounds and saturates, and rebuilds the world box. Depends on afc_pkg.
module afc_xform
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  field_type                     box_lo [3],
   input  field_type                     box_hi [3],
   input  word_type                      xform  [3],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] bmin   [3],
   output logic signed [COORD_WIDTH-1:0] bmax   [3]
);

   localparam logic signed [63:0] CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

   // stage 1: products
   logic                         v1_ff, v1_in, rdy1;
   logic signed [PROD_WIDTH-1:0] plo_ff [3][3];
   logic signed [PROD_WIDTH-1:0] phi_ff [3][3];
   logic signed [PROD_WIDTH-1:0] plo_in [3][3];
   logic signed [PROD_WIDTH-1:0] phi_in [3][3];
   field_type                    trans_ff [3];
   field_type                    trans_in [3];
   // stage 2: sum and round
   logic                         v2_ff, v2_in, rdy2;
   logic signed [RND_WIDTH-1:0]  rlo_ff [3];
   logic signed [RND_WIDTH-1:0]  rhi_ff [3];
   logic signed [RND_WIDTH-1:0]  rlo_in [3];
   logic signed [RND_WIDTH-1:0]  rhi_in [3];
   // stage 3: saturate, min/max
   logic                         v3_ff, v3_in, rdy3;
   logic signed [COORD_WIDTH-1:0] bmin_ff [3];
   logic signed [COORD_WIDTH-1:0] bmax_ff [3];
   logic signed [COORD_WIDTH-1:0] bmin_in [3];
   logic signed [COORD_WIDTH-1:0] bmax_in [3];

   function automatic logic signed [RND_WIDTH-1:0] round_axis(
      input logic signed [PROD_WIDTH-1:0] p0,
      input logic signed [PROD_WIDTH-1:0] p1,
      input logic signed [PROD_WIDTH-1:0] p2,
      input field_type                    t
   );
      logic signed [ACC_WIDTH-1:0] acc;
      acc = ACC_WIDTH'(p0) + ACC_WIDTH'(p1) + ACC_WIDTH'(p2)
          + (ACC_WIDTH'(t) <<< FRAC_SHIFT) + ACC_WIDTH'(ROUND_BIAS);
      return acc[ACC_WIDTH-1:FRAC_SHIFT];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat(
      input logic signed [RND_WIDTH-1:0] r
   );
      logic signed [63:0] w;
      w = 64'(r);
      if (w > CMAX) w = CMAX;
      if (w < CMIN) w = CMIN;
      return w[COORD_WIDTH-1:0];
   endfunction

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff    : v2_ff;
   assign v3_in = rdy3 ? v2_ff    : v3_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         trans_in[a] = lane16(xform[a], LANE_W);
         for (int k = 0; k < 3; k++) begin
            plo_in[a][k] = lane16(xform[a], 2'(k)) * box_lo[k];
            phi_in[a][k] = lane16(xform[a], 2'(k)) * box_hi[k];
         end
         rlo_in[a] = round_axis(plo_ff[a][0], plo_ff[a][1], plo_ff[a][2], trans_ff[a]);
         rhi_in[a] = round_axis(phi_ff[a][0], phi_ff[a][1], phi_ff[a][2], trans_ff[a]);
      end
   end

   always_comb begin
      logic signed [COORD_WIDTH-1:0] ca, cb;
      for (int a = 0; a < 3; a++) begin
         ca = sat(rlo_ff[a]);
         cb = sat(rhi_ff[a]);
         bmin_in[a] = (ca < cb) ? ca : cb;
         bmax_in[a] = (ca < cb) ? cb : ca;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         trans_ff <= trans_in;
      end
      if (rdy2) begin
         rlo_ff <= rlo_in;
         rhi_ff <= rhi_in;
      end
      if (rdy3) begin
         bmin_ff <= bmin_in;
         bmax_ff <= bmax_in;
      end
   end

   assign out_valid = v3_ff;
   assign bmin      = bmin_ff;
   assign bmax      = bmax_ff;

endmodule

FILE: design/afc_plane_test.sv
// afc_plane_test: two-stage pipeline that tests the world box against the six
// planes (positive-vertex products, then signed sums). Depends on afc_pkg.
module afc_plane_test
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] bmin   [3],
   input  logic signed [COORD_WIDTH-1:0] bmax   [3],
   input  word_type                      planes [NUM_PLANES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          visible
);

   localparam int PW = COORD_WIDTH + FIELD_WIDTH;
   localparam int DW = COORD_WIDTH + FIELD_WIDTH + 2;

   logic                 v4_ff, v4_in, rdy4;
   logic signed [PW-1:0] prod_ff [NUM_PLANES][3];
   logic signed [PW-1:0] prod_in [NUM_PLANES][3];
   logic                 v5_ff, v5_in, rdy5;
   logic                 vis_ff, vis_in;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;
   assign v4_in    = rdy4 ? in_valid : v4_ff;
   assign v5_in    = rdy5 ? v4_ff    : v5_ff;

   // positive vertex: box max where the normal component is non-negative
   always_comb begin
      field_type n;
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int k = 0; k < 3; k++) begin
            n = lane16(planes[p], 2'(k));
            prod_in[p][k] = n[FIELD_WIDTH-1] ? n * bmin[k] : n * bmax[k];
         end
      end
   end

   // user holds planes static with items in flight, unenforced; d read directly
   always_comb begin
      logic signed [DW-1:0] plane_dist;
      vis_in = 1'b1;
      for (int p = 0; p < NUM_PLANES; p++) begin
         plane_dist = DW'(prod_ff[p][0]) + DW'(prod_ff[p][1]) + DW'(prod_ff[p][2])
                    + (DW'(lane16(planes[p], LANE_W)) <<< D_SHIFT);
         if (plane_dist[DW-1]) vis_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) prod_ff <= prod_in;
      if (rdy5) vis_ff  <= vis_in;
   end

   assign out_valid = v5_ff;
   assign visible   = vis_ff;

endmodule

FILE: design/aabb_frustum_cull.sv
// aabb_frustum_cull: top level; stream ports, plane registers, transform and
// plane-test pipelines. Depends on afc_pkg, afc_csr, afc_xform, afc_plane_test.
//
// Culls one mesh bounding box per clock unless rsp_tready stalls the path.
// Each req transfer carries the local min/max corners (Q12.4) and three
// affine transform columns (Q4.12 coefficients plus Q12.4 translation);
// each rsp transfer carries one visible bit. The path is five register
// stages: corner products, sum with round-half-up to Q12.4, saturation to
// COORD_WIDTH and per-axis min/max, plane products on the positive vertex,
// then the six signed distances and their sign test. Every stage has its
// own valid bit and moves when the stage after it is empty or moving, so
// rsp_tready low stalls only as far back as needed and bubbles are squeezed
// out. The planes are read live by the last two stages: write them only
// while no box is in flight.
module aabb_frustum_cull
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // box_min_x/y/z [47:0], box_max_x/y/z [95:48],
   // xform_col_x [159:96], xform_col_y [223:160], xform_col_z [287:224]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // visible [0], zero fill [7:1]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   word_type                      planes [NUM_PLANES];
   field_type                     box_lo [3];
   field_type                     box_hi [3];
   word_type                      xform  [3];
   logic                          mid_valid, mid_ready;
   logic signed [COORD_WIDTH-1:0] bmin [3];
   logic signed [COORD_WIDTH-1:0] bmax [3];
   logic                          visible;

   // unpack the request transfer
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         box_lo[k] = field_type'(req_tdata[k*FIELD_WIDTH +: FIELD_WIDTH]);
         box_hi[k] = field_type'(req_tdata[(k+3)*FIELD_WIDTH +: FIELD_WIDTH]);
         xform[k]  = req_tdata[6*FIELD_WIDTH + k*WORD_WIDTH +: WORD_WIDTH];
      end
   end

   afc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .planes      (planes)
   );

   afc_xform #(.COORD_WIDTH(COORD_WIDTH)) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .box_lo    (box_lo),
      .box_hi    (box_hi),
      .xform     (xform),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .bmin      (bmin),
      .bmax      (bmax)
   );

   afc_plane_test #(.COORD_WIDTH(COORD_WIDTH)) u_plane_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .bmin      (bmin),
      .bmax      (bmax),
      .planes    (planes),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .visible   (visible)
   );

   assign rsp_tdata = {(RSP_DATA_WIDTH-1)'(0), visible};

endmodule

FILE: sim/aabb_frustum_cull_tb.sv
`timescale 1ns / 100ps
// aabb_frustum_cull_tb: self-checking bench for the bounding-box frustum culler.
// Depends on afc_pkg and aabb_frustum_cull; drives req/rsp streams and the APB port.
module aabb_frustum_cull_tb;
   import afc_pkg::*;

   localparam int COORD_W      = COORD_WIDTH_DEF;
   localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_LO = -COORD_HI - 1;
   localparam int DRAIN_CYCLES = 12;      // pipeline is 5 deep, plus margin
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_PHASES = 8;
   localparam int BOXES_PER_PHASE = 150;
   // plane file holds NUM_PLANES entries; the two slots above it are unused
   localparam int IDX_UNUSED_A = NUM_PLANES;
   localparam int IDX_UNUSED_B = NUM_PLANES + 1;
   localparam int ONE_Q412 = 4096;

   // One req transfer; first member sits in the top bits, so min_x lands at bit 0.
   typedef struct packed {
      logic [WORD_WIDTH-1:0]  col_z;
      logic [WORD_WIDTH-1:0]  col_y;
      logic [WORD_WIDTH-1:0]  col_x;
      logic signed [15:0]     max_z;
      logic signed [15:0]     max_y;
      logic signed [15:0]     max_x;
      logic signed [15:0]     min_z;
      logic signed [15:0]     min_y;
      logic signed [15:0]     min_x;
   } box_item_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   aabb_frustum_cull u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench-side copy of the plane file, updated right after each APB write.
   logic [WORD_WIDTH-1:0] plane_regs [NUM_PLANES];

   box_item_type box_queue [$];   // boxes waiting for the driver
   logic      visible_q [$];      // predicted visible bit per accepted box
   int        mismatch_count = 0;
   int        boxes_sent = 0;
   int        seen_visible = 0;
   int        seen_culled = 0;
   int        plane_sets = 0;
   int        cycle_count = 0;
   int        gap_left = 0;
   int        stall_left = 0;
   bit        steady = 1'b0;      // no gaps and no stalls while set

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic longint sfield(input logic [WORD_WIDTH-1:0] w, input logic [1:0] idx);
      logic signed [15:0] f;
      f = w[16*idx +: 16];
      return longint'(f);
   endfunction

   // One world axis: Q4.12 x Q12.4 products plus translation, round half up
   // to Q12.4, then clamp to the coordinate width.
   function automatic longint world_coord(input logic [WORD_WIDTH-1:0] col,
                                          input longint px, input longint py,
                                          input longint pz);
      longint acc;
      longint r;
      acc = sfield(col, LANE_X) * px + sfield(col, LANE_Y) * py
          + sfield(col, LANE_Z) * pz + sfield(col, LANE_W) * 4096;
      r = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
      if (r > COORD_HI) r = COORD_HI;
      if (r < COORD_LO) r = COORD_LO;
      return r;
   endfunction

   function automatic logic predict_visible(input box_item_type it);
      longint lo [3];
      longint hi [3];
      longint wmin [3];
      longint wmax [3];
      logic [WORD_WIDTH-1:0] col [3];
      longint a, b, plane_dist, n;
      logic vis;
      lo[0] = longint'(it.min_x);  lo[1] = longint'(it.min_y);  lo[2] = longint'(it.min_z);
      hi[0] = longint'(it.max_x);  hi[1] = longint'(it.max_y);  hi[2] = longint'(it.max_z);
      col[0] = it.col_x; col[1] = it.col_y; col[2] = it.col_z;
      for (int k = 0; k < 3; k++) begin
         a = world_coord(col[k], lo[0], lo[1], lo[2]);
         b = world_coord(col[k], hi[0], hi[1], hi[2]);
         wmin[k] = (a < b) ? a : b;
         wmax[k] = (a < b) ? b : a;
      end
      vis = 1'b1;
      for (int i = 0; i < NUM_PLANES; i++) begin
         // d is Q12.4, products are Q14.18: line d up by 14 bits
         plane_dist = sfield(plane_regs[i], LANE_W) * (longint'(1) <<< D_SHIFT);
         for (int k = 0; k < 3; k++) begin
            n = sfield(plane_regs[i], 2'(k));
            plane_dist += n * ((n >= 0) ? wmax[k] : wmin[k]);
         end
         if (plane_dist < 0) vis = 1'b0;
      end
      return vis;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic int rand_s(input int lo, input int hi);
      return int'($urandom_range(0, hi - lo)) + lo;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] make_col(input int cx, input int cy,
                                                      input int cz, input int t);
      return {16'(t), 16'(cz), 16'(cy), 16'(cx)};
   endfunction

   function automatic box_item_type make_box(input int lx, input int ly, input int lz,
                                             input int hx, input int hy, input int hz,
                                             input logic [WORD_WIDTH-1:0] cx,
                                             input logic [WORD_WIDTH-1:0] cy,
                                             input logic [WORD_WIDTH-1:0] cz);
      box_item_type it;
      it.min_x = 16'(lx); it.min_y = 16'(ly); it.min_z = 16'(lz);
      it.max_x = 16'(hx); it.max_y = 16'(hy); it.max_z = 16'(hz);
      it.col_x = cx; it.col_y = cy; it.col_z = cz;
      return it;
   endfunction

   // Plane word: {d, nz, ny, nx}. Mostly frustum-like planes with normals
   // within +-1.0, some raw noise and some zero planes.
   function automatic logic [WORD_WIDTH-1:0] make_plane();
      int r;
      int n [3];
      int d;
      r = $urandom_range(0, 99);
      if (r < 15) return {$urandom, $urandom};
      if (r < 25) return '0;
      for (int k = 0; k < 3; k++) n[k] = rand_s(-16384, 16384);
      d = rand_s(-1600, 9600);
      return make_col(n[0], n[1], n[2], d);
   endfunction

   function automatic box_item_type random_box();
      int r;
      int lo [3];
      int hi [3];
      int c, h, tmp;
      bit near_ident;
      logic [WORD_WIDTH-1:0] col [3];
      int cf [3];
      logic [REQ_DATA_WIDTH-1:0] v;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         // raw noise: every bit of every field
         v = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
         return box_item_type'(v);
      end
      if (r < 30) begin
         // all 18 lanes from the corner values of a 16-bit field
         for (int j = 0; j < 18; j++) begin
            case ($urandom_range(0, 4))
               0: v[16*j +: 16] = 16'h7FFF;
               1: v[16*j +: 16] = 16'h8000;
               2: v[16*j +: 16] = 16'h0000;
               3: v[16*j +: 16] = 16'hFFFF;
               default: v[16*j +: 16] = 16'h0001;
            endcase
         end
         return box_item_type'(v);
      end
      // well-formed box near the origin with a plausible transform
      near_ident = 1'($urandom_range(0, 1));
      for (int k = 0; k < 3; k++) begin
         c = rand_s(-2400, 2400);
         h = rand_s(0, 800);
         lo[k] = c - h;
         hi[k] = c + h;
         if ($urandom_range(0, 9) == 0) begin
            tmp = lo[k]; lo[k] = hi[k]; hi[k] = tmp;
         end
      end
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            if (near_ident)
               cf[k] = (j == k) ? ONE_Q412 + rand_s(-512, 512) : rand_s(-512, 512);
            else
               cf[k] = rand_s(-8192, 8192);
         end
         col[j] = make_col(cf[0], cf[1], cf[2], rand_s(-1600, 1600));
      end
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], col[0], col[1], col[2]);
   endfunction

   // ---------------------------------------------------------------------
   // APB access: setup cycle, access cycle, transfer at the next edge.
   // ---------------------------------------------------------------------
   task automatic write_plane(input int idx, input logic [WORD_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(idx << CSR_IDX_LSB);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx < NUM_PLANES) plane_regs[idx] = value;
   endtask

   task automatic check_plane(input int idx);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_WIDTH'(idx << CSR_IDX_LSB);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // sampled before this edge's updates: the access-phase value
      if (csr_prdata !== plane_regs[idx])
         report_mismatch($sformatf("plane %0d reads %h, want %h",
                                   idx, csr_prdata, plane_regs[idx]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_all_planes();
      for (int i = 0; i < NUM_PLANES; i++) check_plane(i);
      plane_sets++;
   endtask

   // Wait until the driver has nothing left and every predicted result is
   // back, then let the pipeline run dry. Checked just after the edge so
   // that all of the edge's updates have landed.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (box_queue.size() != 0 || req_tvalid || visible_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) box_queue.push_back(random_box());
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents the next queued box once the current transfer is done.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (box_queue.size() != 0) begin
            req_tdata  <= box_queue.pop_front();
            req_tvalid <= 1'b1;
            gap_left   <= steady ? 0 : draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 99) < 25) stall_left <= draw_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each req transfer, check on each rsp transfer.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor_blk
      logic want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            visible_q.push_back(predict_visible(box_item_type'(req_tdata)));
            boxes_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (visible_q.size() == 0) begin
               report_mismatch($sformatf("result visible=%0b with none pending",
                                         rsp_tdata[0]));
            end else begin
               want = visible_q.pop_front();
               if (rsp_tdata[0] !== want)
                  report_mismatch($sformatf("visible=%0b, want %0b (result %0d)",
                                            rsp_tdata[0], want,
                                            seen_visible + seen_culled));
               if (want) seen_visible++;
               else      seen_culled++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, visible_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : sequencer
      logic [WORD_WIDTH-1:0] id_x, id_y, id_z, ones;
      int q;
      id_x = make_col(ONE_Q412, 0, 0, 0);
      id_y = make_col(0, ONE_Q412, 0, 0);
      id_z = make_col(0, 0, ONE_Q412, 0);
      ones = '1;
      for (int i = 0; i < NUM_PLANES; i++) plane_regs[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Planes at reset value: every plane is all zero, nothing gets culled.
      check_all_planes();
      box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, id_x, id_y, id_z));
      box_queue.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                                   id_x, id_y, id_z));
      box_queue.push_back(make_box(32767, 32767, 32767, 32767, 32767, 32767,
                                   ones, ones, ones));
      box_queue.push_back(random_box());
      wait_drained();

      // Axis-aligned cube of +-100.0 units (d = 1600 in Q12.4, unit normals).
      q = 1600;
      write_plane(REG_PLANE_LEFT,   make_col( 16384,      0,      0, q));
      write_plane(REG_PLANE_RIGHT,  make_col(-16384,      0,      0, q));
      write_plane(REG_PLANE_BOTTOM, make_col(     0,  16384,      0, q));
      write_plane(REG_PLANE_TOP,    make_col(     0, -16384,      0, q));
      write_plane(REG_PLANE_FAR,    make_col(     0,      0, -16384, q));
      write_plane(REG_PLANE_NEAR,   make_col(     0,      0,  16384, q));
      check_all_planes();
      steady = 1'b1;
      // inside, straddling, just outside
      box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, id_x, id_y, id_z));
      box_queue.push_back(make_box(1500, 0, 0, 1700, 10, 10, id_x, id_y, id_z));
      box_queue.push_back(make_box(1700, 0, 0, 1800, 10, 10, id_x, id_y, id_z));
      // inverted corners, outside and inside
      box_queue.push_back(make_box(1800, 10, 10, 1700, 0, 0, id_x, id_y, id_z));
      box_queue.push_back(make_box(100, 100, 100, -100, -100, -100, id_x, id_y, id_z));
      // coordinate extremes
      box_queue.push_back(make_box(32767, 32767, 32767, 32767, 32767, 32767,
                                   id_x, id_y, id_z));
      box_queue.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                                   id_x, id_y, id_z));
      // coefficient extremes drive the sums into saturation both ways
      box_queue.push_back(make_box(32767, 32767, 32767, -32768, -32768, -32768,
                                   make_col(32767, 32767, 32767, 0),
                                   make_col(-32768, -32768, -32768, 0),
                                   make_col(-32768, 32767, -32768, 32767)));
      // pure translation at both ends
      box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, make_col(0, 0, 0, 32767),
                                   make_col(0, 0, 0, -32768), make_col(0, 0, 0, 0)));
      // round half up: x lands on the right plane (visible) or just past it
      box_queue.push_back(make_box(2048, 0, 0, -2048, 0, 0,
                                   make_col(1, 0, 0, 1599), id_y, id_z));
      box_queue.push_back(make_box(2048, 0, 0, 2047, 0, 0,
                                   make_col(1, 0, 0, 1600), id_y, id_z));
      box_queue.push_back(make_box(-1, -1, -1, -1, -1, -1, ones, ones, ones));
      queue_random(20);
      wait_drained();

      // Extreme plane words, non-unit normals among them.
      steady = 1'b0;
      write_plane(REG_PLANE_LEFT,   64'h7FFF_7FFF_7FFF_7FFF);
      write_plane(REG_PLANE_RIGHT,  64'h8000_8000_8000_8000);
      write_plane(REG_PLANE_BOTTOM, 64'hFFFF_FFFF_FFFF_FFFF);
      write_plane(REG_PLANE_TOP,    64'h0000_0000_0000_0000);
      write_plane(REG_PLANE_FAR,    64'h7FFF_8000_7FFF_8000);
      write_plane(REG_PLANE_NEAR,   64'h8000_0000_0000_7FFF);
      check_all_planes();
      queue_random(80);
      wait_drained();

      // Random plane sets; every fourth phase runs without gaps or stalls.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady = (p % 4 == 3);
         for (int i = 0; i < NUM_PLANES; i++)
            if ($urandom_range(0, 9) < 7) write_plane(i, make_plane());
         if (p == 2) begin
            // slots past the plane file must not disturb it
            write_plane(IDX_UNUSED_A, {$urandom, $urandom});
            write_plane(IDX_UNUSED_B, {$urandom, $urandom});
         end
         check_all_planes();
         queue_random(BOXES_PER_PHASE);
         wait_drained();
      end

      if (visible_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", visible_q.size()));
      $display("summary: %0d boxes over %0d plane settings, %0d visible, %0d culled",
               boxes_sent, plane_sets, seen_visible, seen_culled);
      $display("summary: %0d mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
